// ----- sv/sfod_pkg.sv -----
package sfod_pkg;

  localparam int FRAME_SIZE_DEF  = 1024;
  localparam int HALF_WINDOW_DEF = 10;

  localparam int BIN_W   = 19;
  localparam int MAG_W   = 19;
  localparam int SQ_W    = 2 * MAG_W;
  localparam int FLUX_W  = 28;
  localparam int IDX_W   = 24;
  localparam int GAIN_W  = 10;
  localparam int FLOOR_W = 20;
  localparam int CFG_W   = 20;
  localparam int CFG_IW  = 1;
  localparam int Q_FRAC  = 8;

  localparam logic [CFG_IW-1:0] CFG_ALPHA_GAIN  = 1'b0;
  localparam logic [CFG_IW-1:0] CFG_NOISE_FLOOR = 1'b1;

  localparam logic OP_BIN   = 1'b0;
  localparam logic OP_FLUSH = 1'b1;

  localparam logic [GAIN_W-1:0]  ALPHA_RESET = 10'd410;
  localparam logic [FLOOR_W-1:0] FLOOR_RESET = 20'd512;

  typedef enum logic [10:0] {
    S_IDLE = 11'b000_0000_0001,
    S_SQ1  = 11'b000_0000_0010,
    S_SQ2  = 11'b000_0000_0100,
    S_SQRT = 11'b000_0000_1000,
    S_UPD  = 11'b000_0001_0000,
    S_DSET = 11'b000_0010_0000,
    S_DRD  = 11'b000_0100_0000,
    S_DACC = 11'b000_1000_0000,
    S_DPRE = 11'b001_0000_0000,
    S_DMUL = 11'b010_0000_0000,
    S_DOUT = 11'b100_0000_0000
  } state_t;

  function automatic logic [MAG_W-1:0] abs_bin(input logic signed [BIN_W-1:0] v);
    logic [BIN_W-1:0] u;
    u = v[BIN_W-1] ? (~v + 1'b1) : v;
    return u;
  endfunction

endpackage

// ----- sv/spectral_flux_onset_detector.sv -----
// Bin request: after acceptance the input stalls through the squaring states S_SQ1 and
// S_SQ2, MAG_W square root iterations and the update state S_UPD.
// A frame end adds one decision once HALF_WINDOW+1 frames are held: S_DRD and S_DACC per
// windowed frame read from the flux ring, GAIN_W shift-add multiply steps and the setup
// and output states S_DSET, S_DPRE and S_DOUT, where it waits while the output is stalled.
// A flush request runs up to HALF_WINDOW such decisions back to back.
// Reset (rst_n low, synchronous) clears control state; magnitude and ring stores hold.
module spectral_flux_onset_detector
  import sfod_pkg::*;
#(
  parameter int FRAME_SIZE  = FRAME_SIZE_DEF,
  parameter int HALF_WINDOW = HALF_WINDOW_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic                     in_operation,
  input  logic signed [BIN_W-1:0]  in_bin_real,
  input  logic signed [BIN_W-1:0]  in_bin_imag,
  input  logic                     in_last_bin,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [IDX_W-1:0]         out_frame_index,
  output logic                     out_is_onset,
  output logic [FLUX_W-1:0]        out_flux_value,
  output logic                     out_last_frame,
  input  logic                     cfg_wr_en,
  input  logic [CFG_IW-1:0]        cfg_index,
  input  logic [CFG_W-1:0]         cfg_wdata
);

  localparam int NBINS  = FRAME_SIZE / 2 - 1;
  localparam int MDEPTH = FRAME_SIZE / 2;
  localparam int MA_W   = $clog2(MDEPTH);
  localparam int HDEPTH = 2 * HALF_WINDOW + 1;
  localparam int PTR_W  = $clog2(HDEPTH);
  localparam int AGE_W  = $clog2(HDEPTH + 1);
  localparam int SUM_W  = FLUX_W + AGE_W;
  localparam int LHS_W  = FLUX_W + AGE_W;
  localparam int RHS_W  = SUM_W + GAIN_W;
  localparam int IT_W   = $clog2(MAG_W + 1);
  localparam int ST_W   = $clog2(GAIN_W + 1);

  localparam logic [MA_W-1:0]  LAST_POS = MA_W'(NBINS - 1);
  localparam logic [AGE_W-1:0] HW_A     = AGE_W'(HALF_WINDOW);
  localparam logic [AGE_W-1:0] HD_A     = AGE_W'(HDEPTH);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(HDEPTH - 1);

  state_t state_r, state_nxt;

  logic [GAIN_W-1:0]  alpha_r;
  logic [FLOOR_W-1:0] floor_r;

  logic [MAG_W-1:0] mag_mem [MDEPTH];
  logic [MAG_W-1:0] mag_rd_r;
  logic [FLUX_W-1:0] ring_mem [HDEPTH];
  logic [FLUX_W-1:0] ring_rd_r;

  logic [MAG_W-1:0]   re_r, im_r;
  logic               lastb_r;
  logic [SQ_W-1:0]    x_r;
  logic [MAG_W+1:0]   rem_r;
  logic [MAG_W-1:0]   root_r;
  logic [IT_W-1:0]    iter_r;

  logic [MA_W-1:0]    pos_r;
  logic [FLUX_W-1:0]  accum_r;
  logic [PTR_W-1:0]   ptr_r;
  logic [AGE_W-1:0]   fill_r;
  logic [IDX_W-1:0]   seen_r;

  logic               flush_r;
  logic [AGE_W-1:0]   age_r, a_r, hi_r, cnt_r;
  logic [SUM_W-1:0]   sum_r;
  logic [FLUX_W-1:0]  f_r, nb_old_r, nb_new_r;
  logic [LHS_W-1:0]   lhs_r, lmc_r;
  logic [RHS_W-1:0]   rhs_r, rmc_r;
  logic [AGE_W-1:0]   csh_r;
  logic [GAIN_W-1:0]  gsh_r;
  logic [ST_W-1:0]    step_r;

  logic               out_valid_r;
  logic [IDX_W-1:0]   out_idx_r;
  logic               out_onset_r;
  logic [FLUX_W-1:0]  out_flux_r;
  logic               out_last_r;

  logic [MAG_W+1:0]   sh_rem, trial;
  logic [MAG_W:0]     inc_sum;
  logic [FLUX_W:0]    flux_sum;
  logic [FLUX_W-1:0]  flux_upd;
  logic               frame_end;
  logic [PTR_W-1:0]   ptr_next;
  logic [AGE_W-1:0]   fill_next;
  logic [AGE_W:0]     addr_wide;
  logic [PTR_W-1:0]   ring_addr;
  logic [AGE_W-1:0]   older, newer;
  logic               peak_ok, onset;
  logic               out_free;
  logic [AGE_W-1:0]   pending;

  assign in_stall        = (state_r != S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_frame_index = out_idx_r;
  assign out_is_onset    = out_onset_r;
  assign out_flux_value  = out_flux_r;
  assign out_last_frame  = out_last_r;
  assign out_free        = !out_valid_r || !out_stall;

  // One bit of the square root per cycle.
  assign sh_rem = {rem_r[MAG_W-1:0], x_r[SQ_W-1 -: 2]};
  assign trial  = {root_r, 2'b01};

  assign inc_sum  = {1'b0, root_r} - {1'b0, mag_rd_r};
  assign flux_sum = {1'b0, accum_r} + {{(FLUX_W-MAG_W+1){1'b0}}, inc_sum[MAG_W-1:0]};
  always_comb begin
    flux_upd = accum_r;
    if (fill_r != '0 && root_r > mag_rd_r) begin
      flux_upd = flux_sum[FLUX_W] ? {FLUX_W{1'b1}} : flux_sum[FLUX_W-1:0];
    end
  end
  assign frame_end = lastb_r || (pos_r >= LAST_POS);
  assign ptr_next  = (ptr_r == PTR_LAST) ? '0 : ptr_r + 1'b1;
  assign fill_next = (fill_r == HD_A) ? fill_r : fill_r + 1'b1;

  // Ring slot of the frame a_r frames older than the newest.
  always_comb begin
    if ({{(AGE_W-PTR_W){1'b0}}, ptr_r} >= a_r) begin
      addr_wide = {{(AGE_W-PTR_W+1){1'b0}}, ptr_r} - {1'b0, a_r};
    end else begin
      addr_wide = {{(AGE_W-PTR_W+1){1'b0}}, ptr_r} + {1'b0, HD_A} - {1'b0, a_r};
    end
  end
  assign ring_addr = addr_wide[PTR_W-1:0];

  always_comb begin
    older = fill_r - 1'b1 - age_r;
    if (older > HW_A) older = HW_A;
    newer = (age_r > HW_A) ? HW_A : age_r;
  end

  assign peak_ok = (age_r + 1'b1 < fill_r) && (age_r != '0) && (f_r > nb_old_r)
                   && (f_r > nb_new_r) && (f_r >= {{(FLUX_W-FLOOR_W){1'b0}}, floor_r});
  assign onset   = peak_ok
                   && ({{(GAIN_W-Q_FRAC){1'b0}}, lhs_r, {Q_FRAC{1'b0}}} >= rhs_r);
  assign pending = (fill_r < HW_A) ? fill_r : HW_A;

  always_ff @(posedge clk) begin
    if (state_r == S_IDLE) begin
      mag_rd_r <= mag_mem[pos_r];
    end
    if (state_r == S_UPD) begin
      mag_mem[pos_r] <= root_r;
    end
  end

  always_ff @(posedge clk) begin
    ring_rd_r <= ring_mem[ring_addr];
    if (state_r == S_UPD && frame_end) begin
      ring_mem[ptr_next] <= flux_upd;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (in_operation == OP_BIN) state_nxt = S_SQ1;
          else if (pending != '0)     state_nxt = S_DSET;
        end
      end
      S_SQ1:  state_nxt = S_SQ2;
      S_SQ2:  state_nxt = S_SQRT;
      S_SQRT: if (iter_r == IT_W'(MAG_W - 1)) state_nxt = S_UPD;
      S_UPD: begin
        if (frame_end && fill_next >= HW_A + 1'b1) state_nxt = S_DSET;
        else state_nxt = S_IDLE;
      end
      S_DSET: state_nxt = S_DRD;
      S_DRD:  state_nxt = S_DACC;
      S_DACC: state_nxt = (a_r == hi_r) ? S_DPRE : S_DRD;
      S_DPRE: state_nxt = S_DMUL;
      S_DMUL: if (step_r == ST_W'(GAIN_W - 1)) state_nxt = S_DOUT;
      S_DOUT: begin
        if (out_free) state_nxt = (flush_r && age_r != '0) ? S_DSET : S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      alpha_r     <= ALPHA_RESET;
      floor_r     <= FLOOR_RESET;
      pos_r       <= '0;
      accum_r     <= '0;
      ptr_r       <= '0;
      fill_r      <= '0;
      seen_r      <= '0;
      flush_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) begin
        unique case (cfg_index)
          CFG_ALPHA_GAIN:  alpha_r <= cfg_wdata[GAIN_W-1:0];
          CFG_NOISE_FLOOR: floor_r <= cfg_wdata[FLOOR_W-1:0];
          default: ;
        endcase
      end
      if (out_valid_r && !out_stall && state_r != S_DOUT) out_valid_r <= 1'b0;

      unique case (state_r)
        S_IDLE: begin
          if (in_valid && in_operation == OP_FLUSH) begin
            flush_r <= 1'b1;
            age_r   <= pending - 1'b1;
            if (pending == '0) begin
              pos_r   <= '0;
              accum_r <= '0;
              ptr_r   <= '0;
              fill_r  <= '0;
              seen_r  <= '0;
            end
          end
        end
        S_UPD: begin
          if (frame_end) begin
            accum_r <= '0;
            pos_r   <= '0;
            ptr_r   <= ptr_next;
            fill_r  <= fill_next;
            seen_r  <= seen_r + 1'b1;
            flush_r <= 1'b0;
            age_r   <= HW_A;
          end else begin
            accum_r <= flux_upd;
            pos_r   <= pos_r + 1'b1;
          end
        end
        S_DOUT: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            if (flush_r) begin
              if (age_r != '0) begin
                age_r <= age_r - 1'b1;
              end else begin
                pos_r   <= '0;
                accum_r <= '0;
                ptr_r   <= '0;
                fill_r  <= '0;
                seen_r  <= '0;
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Datapath registers without reset.
  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        re_r    <= abs_bin(in_bin_real);
        im_r    <= abs_bin(in_bin_imag);
        lastb_r <= in_last_bin;
      end
      S_SQ1: begin
        x_r <= {{MAG_W{1'b0}}, re_r} * {{MAG_W{1'b0}}, re_r};
      end
      S_SQ2: begin
        x_r    <= x_r + {{MAG_W{1'b0}}, im_r} * {{MAG_W{1'b0}}, im_r};
        rem_r  <= '0;
        root_r <= '0;
        iter_r <= '0;
      end
      S_SQRT: begin
        x_r    <= {x_r[SQ_W-3:0], 2'b00};
        iter_r <= iter_r + 1'b1;
        if (sh_rem >= trial) begin
          rem_r  <= sh_rem - trial;
          root_r <= {root_r[MAG_W-2:0], 1'b1};
        end else begin
          rem_r  <= sh_rem;
          root_r <= {root_r[MAG_W-2:0], 1'b0};
        end
      end
      S_DSET: begin
        a_r      <= age_r - newer;
        hi_r     <= age_r + older;
        cnt_r    <= older + newer + 1'b1;
        sum_r    <= '0;
        nb_old_r <= '0;
        nb_new_r <= '0;
      end
      S_DACC: begin
        sum_r <= sum_r + {{AGE_W{1'b0}}, ring_rd_r};
        if (a_r == age_r)         f_r      <= ring_rd_r;
        if (a_r == age_r + 1'b1)  nb_old_r <= ring_rd_r;
        if (a_r + 1'b1 == age_r)  nb_new_r <= ring_rd_r;
        a_r <= a_r + 1'b1;
      end
      S_DPRE: begin
        lhs_r  <= '0;
        rhs_r  <= '0;
        lmc_r  <= {{AGE_W{1'b0}}, f_r - {{(FLUX_W-FLOOR_W){1'b0}}, floor_r}};
        rmc_r  <= {{GAIN_W{1'b0}}, sum_r};
        csh_r  <= cnt_r;
        gsh_r  <= alpha_r;
        step_r <= '0;
      end
      S_DMUL: begin
        if (csh_r[0]) lhs_r <= lhs_r + lmc_r;
        if (gsh_r[0]) rhs_r <= rhs_r + rmc_r;
        lmc_r  <= {lmc_r[LHS_W-2:0], 1'b0};
        rmc_r  <= {rmc_r[RHS_W-2:0], 1'b0};
        csh_r  <= {1'b0, csh_r[AGE_W-1:1]};
        gsh_r  <= {1'b0, gsh_r[GAIN_W-1:1]};
        step_r <= step_r + 1'b1;
      end
      S_DOUT: begin
        if (out_free) begin
          out_idx_r   <= seen_r - 1'b1 - {{(IDX_W-AGE_W){1'b0}}, age_r};
          out_onset_r <= onset;
          out_flux_r  <= f_r;
          out_last_r  <= flush_r && (age_r == '0);
        end
      end
      default: ;
    endcase
  end

endmodule

// ----- test/onset_checker.sv -----
module onset_checker
  import sfod_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  input  logic                    in_stall,
  input  logic                    in_operation,
  input  logic signed [BIN_W-1:0] in_bin_real,
  input  logic signed [BIN_W-1:0] in_bin_imag,
  input  logic                    in_last_bin,
  input  logic                    out_valid,
  input  logic                    out_stall,
  input  logic [IDX_W-1:0]        out_frame_index,
  input  logic                    out_is_onset,
  input  logic [FLUX_W-1:0]       out_flux_value,
  input  logic                    out_last_frame,
  input  logic                    cfg_wr_en,
  input  logic [CFG_IW-1:0]       cfg_index,
  input  logic [CFG_W-1:0]        cfg_wdata,
  output int                      error_count,
  output int                      decisions_owed
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NBINS = FRAME_SIZE_DEF / 2 - 1;
  localparam int HW    = HALF_WINDOW_DEF;
  localparam int DEPTH = 2 * HW + 1;
  localparam longint unsigned FLUX_TOP = (64'd1 << FLUX_W) - 1;

  typedef struct {
    logic [IDX_W-1:0]  frame_index;
    logic              is_onset;
    logic [FLUX_W-1:0] flux;
    logic              last_frame;
  } decision_t;

  decision_t          owed_decisions[$];
  logic [GAIN_W-1:0]  gain;
  logic [FLOOR_W-1:0] floor_lvl;
  longint unsigned    mag_prev[NBINS];
  longint unsigned    flux_run;
  int                 bin_slot;
  longint unsigned    flux_ring[DEPTH];
  int                 ring_head;
  int                 ring_count;
  logic [IDX_W-1:0]   frame_count;

  assign decisions_owed = owed_decisions.size();

  function automatic longint unsigned mag_of(input logic signed [BIN_W-1:0] re,
                                             input logic signed [BIN_W-1:0] im);
    longint signed   a;
    longint signed   b;
    longint unsigned sq;
    longint unsigned r;
    longint unsigned t;
    a = re;
    b = im;
    if (a < 0) a = -a;
    if (b < 0) b = -b;
    sq = a * a + b * b;
    r = 0;
    for (int k = 19; k >= 0; k--) begin
      t = r | (64'd1 << k);
      if (t * t <= sq) r = t;
    end
    return r;
  endfunction

  function automatic longint unsigned ring_at(input int age);
    return flux_ring[(ring_head + DEPTH - (age % DEPTH)) % DEPTH];
  endfunction

  task automatic decide_frame(input int age, input logic last);
    int              older;
    int              newer;
    longint unsigned total;
    longint unsigned f;
    decision_t       d;
    older = ring_count - 1 - age;
    newer = age;
    if (older > HW) older = HW;
    if (newer > HW) newer = HW;
    total = 0;
    for (int a = age - newer; a <= age + older; a++) total += ring_at(a);
    f = ring_at(age);
    d.is_onset = 1'b0;
    if (age + 1 < ring_count && age > 0 && f > ring_at(age + 1) && f > ring_at(age - 1)
        && f >= floor_lvl)
      d.is_onset = ((f - floor_lvl) * (older + newer + 1) * 256) >= (total * gain);
    d.frame_index = IDX_W'(frame_count - 1 - age);
    d.flux = FLUX_W'(f);
    d.last_frame = last;
    owed_decisions.push_back(d);
  endtask

  task automatic take_request();
    longint unsigned mag;
    int              pos;
    int              pending;
    if (in_operation == OP_FLUSH) begin
      pending = ring_count < HW ? ring_count : HW;
      for (int k = 0; k < pending; k++) decide_frame(pending - 1 - k, (pending - 1 - k) == 0);
      flux_run = 0;
      bin_slot = 0;
      frame_count = '0;
      ring_count = 0;
      ring_head = 0;
    end else begin
      mag = mag_of(in_bin_real, in_bin_imag);
      pos = bin_slot >= NBINS ? NBINS - 1 : bin_slot;
      if (ring_count > 0 && mag > mag_prev[pos]) begin
        flux_run += mag - mag_prev[pos];
        if (flux_run > FLUX_TOP) flux_run = FLUX_TOP;
      end
      mag_prev[pos] = mag;
      if (in_last_bin || pos + 1 >= NBINS) begin
        ring_head = (ring_head + 1) % DEPTH;
        flux_ring[ring_head] = flux_run;
        if (ring_count < DEPTH) ring_count++;
        flux_run = 0;
        bin_slot = 0;
        frame_count++;
        if (ring_count >= HW + 1) decide_frame(HW, 1'b0);
      end else begin
        bin_slot = pos + 1;
      end
    end
  endtask

  initial begin
    error_count = 0;
    gain = ALPHA_RESET;
    floor_lvl = FLOOR_RESET;
    flux_run = 0;
    bin_slot = 0;
    ring_head = 0;
    ring_count = 0;
    frame_count = '0;
    for (int i = 0; i < NBINS; i++) mag_prev[i] = 0;
    for (int i = 0; i < DEPTH; i++) flux_ring[i] = 0;
  end

  always @(posedge clk) begin
    decision_t want;
    if (rst_n) begin
      if (cfg_wr_en) begin
        if (cfg_index == CFG_ALPHA_GAIN) gain = cfg_wdata[GAIN_W-1:0];
        else if (cfg_index == CFG_NOISE_FLOOR) floor_lvl = cfg_wdata[FLOOR_W-1:0];
      end
      if (in_valid && !in_stall) take_request();
      if (out_valid && !out_stall) begin
        if (owed_decisions.size() == 0) begin
          error_count++;
          $display("%0t: unexpected decision for frame %0d", $time, out_frame_index);
        end else begin
          want = owed_decisions.pop_front();
          if (out_frame_index !== want.frame_index) begin
            error_count++;
            $display("%0t: frame_index expected %0d actual %0d", $time,
                     want.frame_index, out_frame_index);
          end
          if (out_is_onset !== want.is_onset) begin
            error_count++;
            $display("%0t: is_onset of frame %0d expected %0b actual %0b", $time,
                     want.frame_index, want.is_onset, out_is_onset);
          end
          if (out_flux_value !== want.flux) begin
            error_count++;
            $display("%0t: flux_value of frame %0d expected %0d actual %0d", $time,
                     want.frame_index, want.flux, out_flux_value);
          end
          if (out_last_frame !== want.last_frame) begin
            error_count++;
            $display("%0t: last_frame of frame %0d expected %0b actual %0b", $time,
                     want.frame_index, want.last_frame, out_last_frame);
          end
        end
      end
    end
  end

endmodule

// ----- test/testbench.sv -----
module testbench;
  import sfod_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SETTLE_CYCLES = 800;

  logic                    clk;
  logic                    rst_n;
  logic                    in_valid;
  logic                    in_stall;
  logic                    in_operation;
  logic signed [BIN_W-1:0] in_bin_real;
  logic signed [BIN_W-1:0] in_bin_imag;
  logic                    in_last_bin;
  logic                    out_valid;
  logic                    out_stall;
  logic [IDX_W-1:0]        out_frame_index;
  logic                    out_is_onset;
  logic [FLUX_W-1:0]       out_flux_value;
  logic                    out_last_frame;
  logic                    cfg_wr_en;
  logic [CFG_IW-1:0]       cfg_index;
  logic [CFG_W-1:0]        cfg_wdata;
  int                      error_count;
  int                      decisions_owed;
  int                      send_idle_pct;
  int                      recv_idle_pct;
  int                      requests_sent;
  bit                      hold_wanted;

  spectral_flux_onset_detector u_dut (.*);
  onset_checker u_checker (.*);

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("FAILURE");
    $finish;
  end

  // The receiver owns its long hold-off: once asked, it stalls for a fixed stretch.
  initial begin
    int hold_left;
    bit hold_done;
    hold_left = 0;
    hold_done = 0;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_wanted && !hold_done) begin
        hold_left = 3000;
        hold_done = 1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
      end
    end
  end

  task automatic send(input logic op, input logic signed [BIN_W-1:0] re,
                      input logic signed [BIN_W-1:0] im, input logic last);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_operation <= op;
    in_bin_real <= re;
    in_bin_imag <= im;
    in_last_bin <= last;
    do @(posedge clk); while (in_stall);
    requests_sent++;
  endtask

  function automatic logic signed [BIN_W-1:0] rand_bin(input int scale);
    case (scale)
      0: return BIN_W'(int'($urandom_range(0, 31)) - 16);
      1: return BIN_W'(int'($urandom_range(0, 8191)) - 4096);
      default: return BIN_W'($urandom);
    endcase
  endfunction

  task automatic send_frame(input int nbins);
    int scale;
    scale = $urandom_range(0, 2);
    for (int b = 0; b < nbins; b++)
      send(OP_BIN, rand_bin(scale), rand_bin(scale), b == nbins - 1);
  endtask

  task automatic write_reg(input logic [CFG_IW-1:0] idx, input logic [CFG_W-1:0] value);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  // Pause the sender until every owed decision is out and the block has gone quiet.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (decisions_owed != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic random_stream(input int count);
    int stop_at;
    int r;
    stop_at = requests_sent + count;
    while (requests_sent < stop_at) begin
      r = $urandom_range(0, 29);
      if (r == 0) begin
        send(OP_FLUSH, rand_bin(2), rand_bin(2), 1'($urandom_range(0, 1)));
      end else if (r == 1) begin
        // Broken frame: a partial frame that the flush throws away.
        send_frame(0);
        for (int b = $urandom_range(1, 3); b > 0; b--) send(OP_BIN, rand_bin(2), rand_bin(2), 1'b0);
        send(OP_FLUSH, '0, '0, 1'b0);
      end else begin
        send_frame($urandom_range(1, 4));
      end
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_operation = OP_BIN;
    in_bin_real = '0;
    in_bin_imag = '0;
    in_last_bin = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_index = CFG_ALPHA_GAIN;
    cfg_wdata = '0;
    send_idle_pct = 6;
    recv_idle_pct = 47;
    requests_sent = 0;
    hold_wanted = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    write_reg(CFG_ALPHA_GAIN, '0);
    write_reg(CFG_NOISE_FLOOR, '0);

    // The first frame is longer than any later frame, so every magnitude slot that is
    // read later has been written; it carries the extreme bin values.
    send(OP_BIN, -19'sd262144, -19'sd262144, 1'b0);
    send(OP_BIN, 19'sd262143, 19'sd262143, 1'b0);
    send(OP_BIN, 19'sd0, 19'sd0, 1'b0);
    send(OP_BIN, -19'sd1, 19'sd1, 1'b0);
    send(OP_BIN, 19'sd262143, -19'sd262144, 1'b0);
    send(OP_BIN, -19'sd262144, 19'sd262143, 1'b1);
    for (int f = 0; f < 12; f++) send_frame(1 + f % 3);
    send(OP_FLUSH, '0, '0, 1'b0);
    send(OP_FLUSH, '0, '0, 1'b1);
    send_frame(2);
    send(OP_FLUSH, '0, '0, 1'b0);
    random_stream(80);
    drain();

    send_idle_pct = 47;
    recv_idle_pct = 6;
    write_reg(CFG_ALPHA_GAIN, CFG_W'(1023));
    write_reg(CFG_NOISE_FLOOR, 20'hFFFFF);
    random_stream(40);
    drain();
    write_reg(CFG_NOISE_FLOOR, CFG_W'($urandom_range(0, 4096)));
    write_reg(CFG_ALPHA_GAIN, CFG_W'($urandom_range(0, 1023)));
    random_stream(40);
    drain();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_reg(CFG_ALPHA_GAIN, CFG_W'(ALPHA_RESET));
    write_reg(CFG_NOISE_FLOOR, CFG_W'(FLOOR_RESET));
    hold_wanted = 1;
    random_stream(80);
    send(OP_FLUSH, '0, '0, 1'b0);
    drain();

    if (error_count == 0 && decisions_owed == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
